/* sv/lfd_pkg.sv */
// ----------------------------------------------------------------------------
// lfd_pkg: shared types and constants of the light flicker detector
// Field widths, register codes and the beats passed between the stages.
// ----------------------------------------------------------------------------
package lfd_pkg;

  localparam int SAMPLE_W = 12;  // light converter reading
  localparam int LAST_W   = 16;  // held sample, wide enough for the reset marker
  localparam int SWING_W  = 12;  // swing between two readings of 12 bits
  localparam int SUM_W    = 20;  // running sum of the swing cells
  localparam int AVG_W    = 16;
  localparam int CFG_W    = 16;
  localparam int TICKS_W  = 17;
  localparam int CFG_IDX_W = 1;

  localparam logic [LAST_W-1:0]  LAST_RESET = 16'd50000;
  localparam logic [CFG_W-1:0]   THRESHOLD_RESET = 16'd40;
  localparam logic [CFG_W-1:0]   REFRESH_RESET = 16'd1000;
  localparam logic [TICKS_W-1:0] TICKS_MAX = {TICKS_W{1'b1}};

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH   = 1'b1;

  // Lens state, one-hot
  typedef enum logic [1:0] {
    ST_SEEING = 2'b01,
    ST_BLIND  = 2'b10
  } lens_state_e;

  typedef struct packed {
    logic [CFG_W-1:0] blind_level;
    logic [CFG_W-1:0] clear_wait;
  } cfg_t;

  // Beat leaving the turning point front end
  typedef struct packed {
    logic             turn;
    logic [SUM_W-1:0] sum;
  } front_t;

  // Pipeline control from the top level
  typedef struct packed {
    logic accept;   // input beat taken
    logic load_b;   // divide stage takes the front beat
    logic load_c;   // state stage takes the divide beat
  } pipe_ctrl_t;

  typedef struct packed {
    logic [AVG_W-1:0] average_swing;
    logic             blinded;
    logic             blind_pulse;
    logic             sight_pulse;
    logic             turning_point;
  } result_t;

endpackage

/* sv/lfd_swing_cell.sv */
// ----------------------------------------------------------------------------
// lfd_swing_cell: one slot of the swing history
// Holds one swing and hands it to the next cell when a turning point shifts
// the chain.
// ----------------------------------------------------------------------------
module lfd_swing_cell import lfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  logic [SWING_W-1:0] swing_i,
  output logic [SWING_W-1:0] swing_o
);

  logic [SWING_W-1:0] swing_q, swing_d;

  assign swing_d = shift_i ? swing_i : swing_q;

  // History is cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swing_q <= '0;
    end else begin
      swing_q <= swing_d;
    end
  end

  assign swing_o = swing_q;

endmodule

/* sv/lfd_front.sv */
// ----------------------------------------------------------------------------
// lfd_front: turning point detection and swing history
// Finds turning points, shifts the swing into the cell chain and keeps the
// running sum of all cells.
// ----------------------------------------------------------------------------
module lfd_front import lfd_pkg::*; #(
  parameter int SLOTS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output front_t              front_o
);

  logic [LAST_W-1:0]   last_q, last_d;
  logic [SWING_W-1:0]  turn_lvl_q, turn_lvl_d;
  logic                rising_q, rising_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic                turn_q, turn_d;
  logic [LAST_W-1:0]   sample_ext;
  logic                turn;
  logic [SWING_W-1:0]  last_lvl;
  logic [SWING_W-1:0]  swing;
  logic                shift;
  logic [SWING_W-1:0]  chain [SLOTS+1];

  assign sample_ext = LAST_W'(sample_i);
  // After the first beat the held sample always fits the swing width
  assign last_lvl   = last_q[SWING_W-1:0];

  // Turning point and swing since the previous one
  assign turn  = (rising_q && (sample_ext < last_q)) || (!rising_q && (sample_ext > last_q));
  assign swing = (last_lvl >= turn_lvl_q) ? (last_lvl - turn_lvl_q) : (turn_lvl_q - last_lvl);
  assign shift = accept_i && turn;

  // Chain of swing cells: newest enters cell 0, oldest leaves the last cell
  assign chain[0] = swing;
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    lfd_swing_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .swing_i(chain[g]),
      .swing_o(chain[g+1])
    );
  end

  // State update per accepted beat
  always_comb begin
    last_d     = last_q;
    turn_lvl_d = turn_lvl_q;
    rising_d   = rising_q;
    sum_d      = sum_q;
    turn_d     = turn_q;
    if (accept_i) begin
      last_d = sample_ext;
      turn_d = turn;
      if (turn) begin
        sum_d      = sum_q - SUM_W'(chain[SLOTS]) + SUM_W'(swing);
        turn_lvl_d = last_lvl;
        rising_d   = !rising_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q     <= LAST_RESET;
      turn_lvl_q <= '0;
      rising_q   <= 1'b0;
      sum_q      <= '0;
      turn_q     <= 1'b0;
    end else begin
      last_q     <= last_d;
      turn_lvl_q <= turn_lvl_d;
      rising_q   <= rising_d;
      sum_q      <= sum_d;
      turn_q     <= turn_d;
    end
  end

  assign front_o.turn = turn_q;
  assign front_o.sum  = sum_q;

endmodule

/* sv/lfd_blind_fsm.sv */
// ----------------------------------------------------------------------------
// lfd_blind_fsm: average swing and seeing/blind state
// Divides the running sum by the slot count through a reciprocal multiply,
// then runs the blind state machine and holds the result beat.
// ----------------------------------------------------------------------------
module lfd_blind_fsm import lfd_pkg::*; #(
  parameter int SLOTS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pipe_ctrl_t ctrl_i,
  input  front_t     front_i,
  input  cfg_t       cfg_i,
  output result_t    result_o
);

  // floor(x / SLOTS) == (x * RECIP) >> SHIFT for every x below 2^SUM_W
  localparam int SHIFT  = SUM_W + $clog2(SLOTS);
  localparam int RECIP_W = SUM_W + 2;
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + SLOTS - 1) / SLOTS;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  logic [PROD_W-1:0]  prod_q, prod_d;
  logic               turn_b_q, turn_b_d;
  logic [AVG_W-1:0]   avg;
  lens_state_e        state_q, state_d;
  logic [TICKS_W-1:0] ticks_q, ticks_d;
  logic [TICKS_W-1:0] ticks_inc;
  result_t            res_q, res_d;

  // Divide stage
  assign prod_d   = ctrl_i.load_b ? (PROD_W'(front_i.sum) * PROD_W'(RECIP)) : prod_q;
  assign turn_b_d = ctrl_i.load_b ? front_i.turn : turn_b_q;

  assign avg = prod_q[SHIFT +: AVG_W];
  assign ticks_inc = (ticks_q < TICKS_MAX) ? (ticks_q + 1'b1) : ticks_q;

  // Blind state machine
  always_comb begin
    state_d = state_q;
    ticks_d = ticks_q;
    res_d   = res_q;
    if (ctrl_i.load_c) begin
      res_d.average_swing = avg;
      res_d.turning_point = turn_b_q;
      res_d.blind_pulse   = 1'b0;
      res_d.sight_pulse   = 1'b0;
      unique case (state_q)
        ST_SEEING: begin
          if (avg > cfg_i.blind_level) begin
            state_d           = ST_BLIND;
            ticks_d           = '0;
            res_d.blind_pulse = 1'b1;
          end
        end
        ST_BLIND: begin
          ticks_d = ticks_inc;
          if ((ticks_inc > TICKS_W'(cfg_i.clear_wait)) &&
              (avg < cfg_i.blind_level)) begin
            state_d           = ST_SEEING;
            res_d.sight_pulse = 1'b1;
          end
        end
        default: begin
          state_d = ST_SEEING;
        end
      endcase
      res_d.blinded = (state_d == ST_BLIND);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SEEING;
      ticks_q <= '0;
    end else begin
      state_q <= state_d;
      ticks_q <= ticks_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    turn_b_q <= turn_b_d;
    res_q    <= res_d;
  end

  assign result_o = res_q;

endmodule

/* sv/light_flicker_detector_core.sv */
// ----------------------------------------------------------------------------
// light_flicker_detector_core: flicker detector top level
// An accepted beat passes the front, divide and result registers in turn.
// Throughput: one sample per cycle; the three stage pipeline moves whenever
// the output register is empty or its beat is taken.
// Reset: asynchronous, clears the swing cells, sum, state, valid and config
// registers at once; the payload registers are not reset; no clearing pass.
// ----------------------------------------------------------------------------
module light_flicker_detector_core import lfd_pkg::*; #(
  parameter int SLOTS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // sample channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SAMPLE_W-1:0]  light_sample_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [AVG_W-1:0]     average_swing_o,
  output logic                 blinded_o,
  output logic                 blind_pulse_o,
  output logic                 sight_pulse_o,
  output logic                 turning_point_o
);

  cfg_t       cfg_q, cfg_d;
  logic       a_valid_q, b_valid_q, out_valid_q;
  logic       advance;
  pipe_ctrl_t ctrl;
  front_t     front;
  result_t    result;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THRESHOLD: cfg_d.blind_level = cfg_data_i;
        REG_REFRESH:   cfg_d.clear_wait  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blind_level <= THRESHOLD_RESET;
      cfg_q.clear_wait  <= REFRESH_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Pipeline control: all stages move together
  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = advance;
  assign ctrl.accept = in_valid_i && advance;
  assign ctrl.load_b = a_valid_q && advance;
  assign ctrl.load_c = b_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      a_valid_q   <= in_valid_i;
      b_valid_q   <= a_valid_q;
      out_valid_q <= b_valid_q;
    end
  end

  lfd_front #(.SLOTS(SLOTS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(ctrl.accept),
    .sample_i(light_sample_i),
    .front_o (front)
  );

  lfd_blind_fsm #(.SLOTS(SLOTS)) u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .front_i (front),
    .cfg_i   (cfg_q),
    .result_o(result)
  );

  assign out_valid_o     = out_valid_q;
  assign average_swing_o = result.average_swing;
  assign blinded_o       = result.blinded;
  assign blind_pulse_o   = result.blind_pulse;
  assign sight_pulse_o   = result.sight_pulse;
  assign turning_point_o = result.turning_point;

endmodule

/* sv/lfd_checker.sv */
// ----------------------------------------------------------------------------
// lfd_checker: port level checks of the flicker detector
// Watches the top level ports and flags inconsistent result beats.
// ----------------------------------------------------------------------------
module lfd_checker import lfd_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [AVG_W-1:0]     average_swing_o,
  input logic                 blinded_o,
  input logic                 blind_pulse_o,
  input logic                 sight_pulse_o,
  input logic                 turning_point_o
);

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable({average_swing_o, blinded_o, blind_pulse_o,
                                             sight_pulse_o, turning_point_o}))
    else $error("result payload changed while stalled");

  // Blinding beat reports the blind state
  a_blind_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && blind_pulse_o |-> blinded_o)
    else $error("blind pulse without blind state");

  // Sight beat reports the seeing state
  a_sight_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sight_pulse_o |-> !blinded_o)
    else $error("sight pulse while blind");

  // A stalled output never blocks the input side from seeing backpressure
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output is stalled");

endmodule

bind light_flicker_detector_core lfd_checker u_lfd_checker (.*);

/* bench/tb_light_flicker_detector_core.sv */
// ----------------------------------------------------------------------------
// tb_light_flicker_detector_core: self-checking bench of the flicker detector
// Drives light samples as flicker bursts, steady levels, ramps and noise over
// several register settings. Each result beat is checked field by field with
// its typed row or with an in-bench model of the swing ring and lens state.
// ----------------------------------------------------------------------------
module tb_light_flicker_detector_core;
  import lfd_pkg::*;

  localparam int SLOTS       = 12;
  localparam int PTR_W       = $clog2(SLOTS);
  localparam int DIR_N       = 22;
  localparam int PHASE_ITEMS = 150;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_THRESHOLD;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [SAMPLE_W-1:0]  light_sample_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [AVG_W-1:0]     average_swing_o;
  logic                 blinded_o;
  logic                 blind_pulse_o;
  logic                 sight_pulse_o;
  logic                 turning_point_o;

  light_flicker_detector_core #(.SLOTS(SLOTS)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .light_sample_i (light_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .average_swing_o(average_swing_o),
    .blinded_o      (blinded_o),
    .blind_pulse_o  (blind_pulse_o),
    .sight_pulse_o  (sight_pulse_o),
    .turning_point_o(turning_point_o)
  );

  // Clock, period 8
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Directed row: sample, typed flag, typed result {avg, blinded, blind, sight, turn}
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                typed;
    result_t             want;
  } dir_row_t;

  dir_row_t dir_rows [DIR_N] = '{
    {12'd0,    1'b1, 16'd0,   4'b0000},  // first sample: no turning point
    {12'd480,  1'b1, 16'd0,   4'b0001},  // first turn, zero swing
    {12'd480,  1'b1, 16'd0,   4'b0000},  // flat
    {12'd0,    1'b1, 16'd40,  4'b0001},  // average equals threshold: stays seeing
    {12'd0,    1'b1, 16'd40,  4'b0000},
    {12'd4095, 1'b1, 16'd80,  4'b1101},  // average above threshold: blinds
    {12'd4095, 1'b1, 16'd80,  4'b1000},
    {12'd0,    1'b1, 16'd421, 4'b1001},  // full scale swing
    {12'hAAA,  1'b0, 16'd0,   4'b0000},
    {12'h555,  1'b0, 16'd0,   4'b0000},
    {12'hFFF,  1'b0, 16'd0,   4'b0000},
    {12'h000,  1'b0, 16'd0,   4'b0000},
    {12'hFFF,  1'b0, 16'd0,   4'b0000},
    {12'h001,  1'b0, 16'd0,   4'b0000},
    {12'hFFE,  1'b0, 16'd0,   4'b0000},
    {12'h800,  1'b0, 16'd0,   4'b0000},
    {12'h7FF,  1'b0, 16'd0,   4'b0000},
    {12'hAAA,  1'b0, 16'd0,   4'b0000},
    {12'h555,  1'b0, 16'd0,   4'b0000},
    {12'hC00,  1'b0, 16'd0,   4'b0000},
    {12'h3FF,  1'b0, 16'd0,   4'b0000},
    {12'hFFF,  1'b0, 16'd0,   4'b0000}   // ring has wrapped by now
  };

  // Register settings of the random phases; later phases pick their own
  typedef struct packed {
    logic [CFG_W-1:0] thr;
    logic [CFG_W-1:0] refr;
    logic             gappy;
    logic             long_hold;
  } phase_t;

  phase_t phase_plan [5] = '{
    {16'd200,   16'd20,    1'b1, 1'b0},
    {16'd65535, 16'd0,     1'b1, 1'b0},
    {16'd0,     16'd65535, 1'b1, 1'b0},
    {16'd500,   16'd5,     1'b0, 1'b1},
    {16'd100,   16'd0,     1'b0, 1'b0}
  };

  // Model state of the detector
  logic [LAST_W-1:0]  lvl_last;
  logic [LAST_W-1:0]  lvl_turn;
  logic               going_up;
  logic [15:0]        swing_cells [SLOTS];
  logic [PTR_W-1:0]   cell_ptr;
  logic [SUM_W-1:0]   swing_total;
  lens_state_e        lens;
  logic [TICKS_W-1:0] tick_count;
  logic [CFG_W-1:0]   thr_reg;
  logic [CFG_W-1:0]   refresh_reg;

  result_t awaited_results [$];
  int      mismatch_count = 0;
  bit      idle_on = 1'b0;
  bit      hold_request = 1'b0;

  // Turning point search, swing ring and lens state for one sample
  function automatic result_t predict_flicker(input logic [SAMPLE_W-1:0] s);
    result_t     r;
    logic [15:0] swing;
    logic [15:0] avg;
    logic        turn;
    r = '0;
    turn = (going_up && s < lvl_last) || (!going_up && s > lvl_last);
    if (turn) begin
      swing = (lvl_last >= lvl_turn) ? lvl_last - lvl_turn : lvl_turn - lvl_last;
      swing_total = swing_total - SUM_W'(swing_cells[cell_ptr]) + SUM_W'(swing);
      swing_cells[cell_ptr] = swing;
      cell_ptr = (cell_ptr == PTR_W'(SLOTS - 1)) ? '0 : cell_ptr + 1'b1;
      lvl_turn = lvl_last;
      going_up = !going_up;
    end
    lvl_last = LAST_W'(s);
    avg = 16'(swing_total / SLOTS);
    if (lens == ST_SEEING && avg > thr_reg) begin
      lens = ST_BLIND;
      tick_count = '0;
      r.blind_pulse = 1'b1;
    end else if (lens == ST_BLIND) begin
      if (tick_count != TICKS_MAX) tick_count = tick_count + 1'b1;
      if (tick_count > refresh_reg && avg < thr_reg) begin
        lens = ST_SEEING;
        r.sight_pulse = 1'b1;
      end
    end
    r.average_swing = avg;
    r.blinded = (lens == ST_BLIND);
    r.turning_point = turn;
    return r;
  endfunction

  // Mostly short gaps, a few long ones; none when idling is off
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Both registers, back to back; called at a rising edge while idle
  task automatic write_regs(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] refr);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_THRESHOLD;
    cfg_data_i <= thr;
    @(posedge clk_i);
    cfg_idx_i  <= REG_REFRESH;
    cfg_data_i <= refr;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    thr_reg     = thr;
    refresh_reg = refr;
  endtask

  // Offer one sample beat, wait for it to be taken, queue its expected result
  task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
                             input result_t want);
    int      gap;
    result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    light_sample_i <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = predict_flicker(s);
    awaited_results.push_back(typed ? want : r);
  endtask

  // Flicker bursts, steady levels, ramps and noise
  task automatic run_random_phase(input int count);
    int                  sent;
    int                  kind;
    int                  len;
    int                  k;
    int                  step;
    logic [SAMPLE_W-1:0] amp;
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] s;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(6, 40);
      step = $urandom_range(1, 50);
      case ($urandom_range(0, 2))
        0: amp = SAMPLE_W'($urandom_range(0, 40));
        1: amp = SAMPLE_W'($urandom_range(40, 700));
        default: amp = SAMPLE_W'($urandom_range(700, 4095));
      endcase
      base = SAMPLE_W'($urandom_range(0, 4095 - amp));
      for (k = 0; k < len && sent < count; k++) begin
        if (kind <= 5) begin
          s = (k % 2) ? base + amp : base;
          if ($urandom_range(0, 3) == 0) s = s ^ SAMPLE_W'($urandom_range(0, 3));
        end else if (kind <= 7) begin
          s = base ^ SAMPLE_W'($urandom_range(0, 3));
        end else if (kind == 8) begin
          s = SAMPLE_W'(base + k * step);
        end else begin
          s = SAMPLE_W'($urandom_range(0, 4095));
        end
        push_sample(s, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Result sink: random stalls, plus one long hold-off when asked
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 300;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        hold_left = pick_gap();
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, got avg %0d", $time,
                 average_swing_o);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("average_swing", want.average_swing, average_swing_o);
        check_field("blinded", 16'(want.blinded), 16'(blinded_o));
        check_field("blind_pulse", 16'(want.blind_pulse), 16'(blind_pulse_o));
        check_field("sight_pulse", 16'(want.sight_pulse), 16'(sight_pulse_o));
        check_field("turning_point", 16'(want.turning_point), 16'(turning_point_o));
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    int i;
    int p;
    lvl_last    = LAST_RESET;
    lvl_turn    = '0;
    going_up    = 1'b0;
    for (i = 0; i < SLOTS; i++) swing_cells[i] = '0;
    cell_ptr    = '0;
    swing_total = '0;
    lens        = ST_SEEING;
    tick_count  = '0;
    thr_reg     = THRESHOLD_RESET;
    refresh_reg = REFRESH_RESET;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows under the reset settings
    idle_on = 1'b1;
    for (i = 0; i < DIR_N; i++) begin
      push_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases, each under its own register setting
    for (p = 0; p < 7; p++) begin
      in_valid_i <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
      if (p < 5) begin
        write_regs(phase_plan[p].thr, phase_plan[p].refr);
        idle_on = phase_plan[p].gappy;
        if (phase_plan[p].long_hold) hold_request = 1'b1;
      end else begin
        write_regs(CFG_W'($urandom_range(10, 1500)), CFG_W'($urandom_range(0, 60)));
        idle_on = 1'b1;
      end
      run_random_phase(PHASE_ITEMS);
    end
    in_valid_i <= 1'b0;

    // Drain, then let the pipeline settle
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
